FILE: hw/rtl/qph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qph_pkg
// Shared widths, codes and types of the quadratic-probe hash table unit.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int KEY_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int TS_W       = 11;
    localparam int COEF_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int SLOTS_DEFAULT = 1024;

    // remainder unit: dividend bits retired per cycle
    localparam int MOD_BITS = 4;

    localparam logic [TS_W-1:0]   TS_RESET   = 11'd1024;
    localparam logic [COEF_W-1:0] LIN_RESET  = 10'd2;
    localparam logic [COEF_W-1:0] QUAD_RESET = 10'd3;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_INSERTED  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FOUND     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NOT_FOUND = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_CLEARED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_QUAD = 2'd2;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [OUTCOME_W-1:0] outcome_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_CLEAR,
        ST_MOD_LIN,
        ST_MOD_QUAD,
        ST_COEF,
        ST_MOD_KEY,
        ST_FETCH,
        ST_PROBE
    } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qph_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qph_req_if
// Request channel: operation code and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qph_req_if
    import qph_pkg::*;
    ();

    logic  valid;
    logic  ready;
    func_t func;
    key_t  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/qph_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qph_rsp_if
// Response channel: outcome, slot and probe count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qph_rsp_if
    import qph_pkg::*;
    ();

    logic     valid;
    logic     ready;
    outcome_t outcome;
    slot_t    slot;
    count_t   probe_count;

    modport source (output valid, output outcome, output slot, output probe_count,
                    input ready);
    modport sink   (input valid, input outcome, input slot, input probe_count,
                    output ready);

endinterface
`default_nettype wire

FILE: hw/rtl/qph_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qph_mod_unit
// Iterative restoring remainder of a 32-bit unsigned value by a runtime
// modulus, MOD_BITS dividend bits per cycle. done pulses when finished.
// ----------------------------------------------------------------------------
module qph_mod_unit
    import qph_pkg::*;
#(
    parameter int MW = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] dividend,
    input  wire logic [MW-1:0]    modulus,
    output logic                  done,
    output logic [MW-1:0]         remainder
);

    localparam int STEPS = KEY_W / MOD_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [KEY_W-1:0] quo_reg, quo_next;

    always_comb
    begin
        logic [MW:0]      t;
        logic [MW-1:0]    rem_v;
        logic [KEY_W-1:0] quo_v;

        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int b = 0; b < MOD_BITS; b++)
        begin
            t     = {rem_v, quo_v[KEY_W-1]};
            quo_v = {quo_v[KEY_W-2:0], 1'b0};
            if (t >= {1'b0, modulus})
            begin
                t = t - {1'b0, modulus};
            end
            rem_v = t[MW-1:0];
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = rem_v;
            quo_next = quo_v;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/qph_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qph_slot_mem
// Slot store: one write port, one read port with registered read data.
// Each word holds the occupied flag above the stored key.
// ----------------------------------------------------------------------------
module qph_slot_mem
    import qph_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEFAULT,
    parameter int AW    = 10
) (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire logic [KEY_W:0] wr_data,
    input  wire logic [AW-1:0]  rd_addr,
    output logic [KEY_W:0]      rd_data
);

    logic [KEY_W:0] mem [DEPTH];
    logic [KEY_W:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/quadratic_probe_hash_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table with quadratic probing; one operation at a time.
// Insert/search: the key is reduced in the shared remainder unit, then the
// slot memory is probed, one probe per cycle on its read port; the first
// insert or search after reset or a register write also reduces the probe
// coefficients. Clear sweeps every slot free. After reset the slot memory is
// swept free; no request is taken meanwhile. Registers reset to size 1024,
// coefficients 2 and 3.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit
    import qph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    qph_req_if.sink                    req,
    qph_rsp_if.source                  rsp,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int MW = IW + 1;

    // configuration
    logic [TS_W-1:0]   ts_reg;
    logic [COEF_W-1:0] lin_reg;
    logic [COEF_W-1:0] quad_reg;
    logic              coef_ok_reg, coef_ok_next;

    // control
    state_t        state_reg, state_next;
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    func_t         func_reg, func_next;
    key_t          key_reg, key_next;
    logic [IW-1:0] lin_m_reg, lin_m_next;
    logic [IW-1:0] quad_m_reg, quad_m_next;
    logic [IW-1:0] d0_reg, d0_next;
    logic [IW-1:0] q2_reg, q2_next;
    logic [IW-1:0] s_reg, s_next;
    logic [IW-1:0] d_reg, d_next;
    logic [MW-1:0] cnt_reg, cnt_next;
    outcome_t      outcome_reg, outcome_next;
    slot_t         slot_reg, slot_next;
    count_t        count_reg, count_next;

    // shared remainder unit
    logic             mod_start;
    logic [KEY_W-1:0] mod_dividend;
    logic             mod_done;
    logic [MW-1:0]    mod_rem;

    // slot memory
    logic           mem_wr_en;
    logic [IW-1:0]  mem_wr_addr;
    logic [KEY_W:0] mem_wr_data;
    logic [IW-1:0]  mem_rd_addr;
    logic [KEY_W:0] mem_rd_data;

    logic [MW-1:0] m_eff;
    logic          out_free;

    always_comb
    begin
        if (ts_reg == '0)
        begin
            m_eff = MW'(1);
        end
        else if (32'(ts_reg) > 32'(SLOTS))
        begin
            m_eff = MW'(SLOTS);
        end
        else
        begin
            m_eff = MW'(ts_reg);
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    qph_mod_unit #(
        .MW (MW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .modulus   (m_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    qph_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        logic [MW:0]        sum_a;
        logic [MW:0]        sum_b;
        logic [IW:0]        s_sum;
        logic [IW:0]        d_sum;
        logic [IW-1:0]      s_adv;
        logic [IW-1:0]      d_adv;
        logic [KEY_W-1:0]   key_u;
        logic [KEY_W-1:0]   key_abs;
        logic [MW-1:0]      home;
        logic [MW-1:0]      cnt_p1;
        logic [IW+SLOT_W-1:0]  slot_ext;
        logic [MW+COUNT_W-1:0] cnt_ext;
        logic               used;
        logic               match;
        logic               is_ins;
        logic               last;

        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        coef_ok_next   = coef_ok_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        lin_m_next     = lin_m_reg;
        quad_m_next    = quad_m_reg;
        d0_next        = d0_reg;
        q2_next        = q2_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        outcome_next   = outcome_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_cnt_reg;
        mem_wr_data = '0;
        mem_rd_addr = s_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // coefficient residues, both terms already below m
        sum_a = {1'b0, MW'(lin_m_reg)} + {1'b0, MW'(quad_m_reg)};
        if (sum_a >= {1'b0, m_eff})
        begin
            sum_a = sum_a - {1'b0, m_eff};
        end
        sum_b = {1'b0, MW'(quad_m_reg)} + {1'b0, MW'(quad_m_reg)};
        if (sum_b >= {1'b0, m_eff})
        begin
            sum_b = sum_b - {1'b0, m_eff};
        end

        // next probe: s += d, d += 2*quad, both mod m
        s_sum = {1'b0, s_reg} + {1'b0, d_reg};
        if (s_sum >= m_eff)
        begin
            s_sum = s_sum - m_eff;
        end
        s_adv = s_sum[IW-1:0];
        d_sum = {1'b0, d_reg} + {1'b0, q2_reg};
        if (d_sum >= m_eff)
        begin
            d_sum = d_sum - m_eff;
        end
        d_adv = d_sum[IW-1:0];

        key_u   = key_reg;
        key_abs = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;
        if (key_u[KEY_W-1] && (mod_rem != '0))
        begin
            home = m_eff - mod_rem;
        end
        else
        begin
            home = mod_rem;
        end

        used     = mem_rd_data[KEY_W];
        match    = (mem_rd_data[KEY_W-1:0] == key_u);
        is_ins   = (func_reg == FUNC_INSERT);
        cnt_p1   = cnt_reg + MW'(1);
        last     = (cnt_p1 == m_eff);
        slot_ext = {{SLOT_W{1'b0}}, s_reg};
        cnt_ext  = {{COUNT_W{1'b0}}, cnt_p1};

        case (state_reg)
            ST_INIT:
            begin
                mem_wr_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == IW'(SLOTS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next    = req.func;
                    key_next     = req.key;
                    clr_cnt_next = '0;
                    state_next   = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                case (func_reg)
                    FUNC_INSERT, FUNC_SEARCH:
                    begin
                        state_next = coef_ok_reg ? ST_MOD_KEY : ST_MOD_LIN;
                    end
                    FUNC_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
                if (clr_cnt_reg != IW'(SLOTS - 1))
                begin
                    clr_cnt_next = clr_cnt_reg + IW'(1);
                end
                else if (out_free)
                begin
                    clr_cnt_next   = '0;
                    out_valid_next = 1'b1;
                    outcome_next   = OUT_CLEARED;
                    slot_next      = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_MOD_LIN:
            begin
                if (mod_done)
                begin
                    lin_m_next = mod_rem[IW-1:0];
                    state_next = ST_MOD_QUAD;
                end
            end

            ST_MOD_QUAD:
            begin
                if (mod_done)
                begin
                    quad_m_next = mod_rem[IW-1:0];
                    state_next  = ST_COEF;
                end
            end

            ST_COEF:
            begin
                d0_next      = sum_a[IW-1:0];
                q2_next      = sum_b[IW-1:0];
                coef_ok_next = 1'b1;
                state_next   = ST_MOD_KEY;
            end

            ST_MOD_KEY:
            begin
                if (mod_done)
                begin
                    s_next     = home[IW-1:0];
                    d_next     = d0_reg;
                    cnt_next   = '0;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (!used || (!is_ins && match) || last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        slot_next      = '0;
                        count_next     = '0;
                        if (is_ins)
                        begin
                            if (!used)
                            begin
                                mem_wr_en    = 1'b1;
                                mem_wr_addr  = s_reg;
                                mem_wr_data  = {1'b1, key_u};
                                outcome_next = OUT_INSERTED;
                                slot_next    = slot_ext[SLOT_W-1:0];
                            end
                            else
                            begin
                                outcome_next = OUT_FULL;
                            end
                        end
                        else
                        begin
                            count_next = cnt_ext[COUNT_W-1:0];
                            if (used && match)
                            begin
                                outcome_next = OUT_FOUND;
                                slot_next    = slot_ext[SLOT_W-1:0];
                            end
                            else
                            begin
                                outcome_next = OUT_NOT_FOUND;
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    s_next      = s_adv;
                    d_next      = d_adv;
                    cnt_next    = cnt_p1;
                    mem_rd_addr = s_adv;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // launch the remainder unit on entry to a reduction state
        mod_start    = 1'b0;
        mod_dividend = key_abs;
        if (state_next != state_reg)
        begin
            case (state_next)
                ST_MOD_LIN:
                begin
                    mod_start    = 1'b1;
                    mod_dividend = KEY_W'(lin_reg);
                end
                ST_MOD_QUAD:
                begin
                    mod_start    = 1'b1;
                    mod_dividend = KEY_W'(quad_reg);
                end
                ST_MOD_KEY:
                begin
                    mod_start    = 1'b1;
                    mod_dividend = key_abs;
                end
                default:
                begin
                    mod_start = 1'b0;
                end
            endcase
        end

        // any register write invalidates the cached residues
        if (cfg_wr_en)
        begin
            coef_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            coef_ok_reg   <= 1'b0;
            ts_reg        <= TS_RESET;
            lin_reg       <= LIN_RESET;
            quad_reg      <= QUAD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            coef_ok_reg   <= coef_ok_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TABLE_SIZE: ts_reg   <= cfg_data[TS_W-1:0];
                    CFG_PROBE_LIN:  lin_reg  <= cfg_data[COEF_W-1:0];
                    CFG_PROBE_QUAD: quad_reg <= cfg_data[COEF_W-1:0];
                    default:        ts_reg   <= ts_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        lin_m_reg   <= lin_m_next;
        quad_m_reg  <= quad_m_next;
        d0_reg      <= d0_next;
        q2_reg      <= q2_next;
        s_reg       <= s_next;
        d_reg       <= d_next;
        cnt_reg     <= cnt_next;
        outcome_reg <= outcome_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.outcome     = outcome_reg;
    assign rsp.slot        = slot_reg;
    assign rsp.probe_count = count_reg;

endmodule
`default_nettype wire
